// ----- design/stdo_pkg.sv -----
// Shared types, codes and saturation helpers for the super-twisting observer.
// No dependencies; imported by the observer top level.
`default_nettype none

package stdo_pkg;

    // Number format default: fraction bits of the signed 32-bit fixed point.
    localparam int FRAC_BITS_DEF = 16;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_GAIN_IQ     = 3'd0;
    localparam logic [2:0] REG_GAIN_DIST   = 3'd1;
    localparam logic [2:0] REG_DIST_STEP   = 3'd2;
    localparam logic [2:0] REG_SPEED_NUM   = 3'd3;
    localparam logic [2:0] REG_SPEED_DEN   = 3'd4;
    localparam logic [2:0] REG_K_ROOT      = 3'd5;
    localparam logic [2:0] REG_DIST_LIMIT  = 3'd6;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd7;

    // Sign term codes as held in state.
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    localparam logic [30:0] LIMIT_MAX = 31'h7fff_ffff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_SQRT,
        ST_MUL,
        ST_ACC,
        ST_TIN,
        ST_FINISH
    } t_state;

    // Products issued to the shared multiplier, in order.
    typedef enum logic [2:0] {
        OP_IQ,
        OP_DIST,
        OP_ROOT,
        OP_TUSTIN,
        OP_FEEDBACK
    } t_op;

    // Sign code to -1/0/+1; the unused code reads as zero.
    function automatic logic signed [1:0] sign_val(input logic [1:0] code);
        logic signed [1:0] v;
        v = 2'sd0;
        if (code == SIGN_POS) v = 2'sd1;
        if (code == SIGN_NEG) v = -2'sd1;
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff)
            r = 32'sh7fff_ffff;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Symmetric clamp to [-lim, lim].
    function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                     input logic [30:0] lim);
        logic signed [32:0] v33;
        logic signed [32:0] lim33;
        logic signed [32:0] r;
        v33   = {v[31], v};
        lim33 = {2'b00, lim};
        if (v33 > lim33)
            r = lim33;
        else if (v33 < -lim33)
            r = -lim33;
        else
            r = v33;
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/super_twisting_disturbance_observer_unit.sv -----
// Super-twisting sliding-mode disturbance observer, top level.
// Depends on stdo_pkg (state and operation codes, saturation helpers).
// Holds the sequencer, the bit-serial square root and the shared multiplier.
//
//  channel   dir  handshake                        payload (low bit first)
//  ------    ---  -------------------------------  --------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata: iq_meas[31:0], speed_meas
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata: speed_est[31:0], dist_est
//  cfg       in   i_cfg_we (no wait, no read-back) i_cfg_addr, i_cfg_wdata
//
// Each sample runs the disturbance update, then the bit-serial square-root loop
// over ceil((33 + FRAC_BITS) / 2) root bits, then five products on the single
// 32x32 multiplier, each multiplied and then accumulated, and a completion step.
// Input is taken only in idle; a finished beat waits in the output register
// while the next sample is taken, and a sample completes only once that
// register is free. Reset (synchronous, active low) clears the observer state
// and loads the default coefficients and limits.
`default_nettype none

module super_twisting_disturbance_observer_unit
    import stdo_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_wdata,
    // sample beats
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [31:0] iq_meas, [63:32] speed_meas
    // result beats
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] speed_est, [63:32] dist_est
);

    // Square root of |e| * 2^FRAC_BITS, |e| up to 33 bits.
    localparam int SQ_XW  = 33 + FRAC_BITS;
    localparam int SQ_RW  = (SQ_XW + 1) / 2;
    localparam int SQ_PW  = 2 * SQ_RW;
    localparam int SQ_CW  = $clog2(SQ_RW);
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

    // configuration registers
    logic signed [31:0] r_gain_iq, r_gain_dist, r_dist_step;
    logic signed [31:0] r_speed_num, r_speed_den, r_k_root;
    logic        [30:0] r_dist_limit, r_speed_limit;

    // observer state
    logic signed [31:0] r_speed_state, r_dist_state, r_prev_drive;
    logic        [1:0]  r_prev_sign;

    // per-sample working registers
    t_state             r_state, n_state;
    t_op                r_op;
    logic signed [31:0] r_iq;
    logic        [1:0]  r_sign;
    logic        [32:0] r_mag;
    logic signed [31:0] r_dist;
    logic signed [31:0] r_drive;
    logic signed [31:0] r_tin;
    logic        [SQ_PW-1:0] r_sq_x;
    logic        [SQ_RW+1:0] r_sq_rem;
    logic        [SQ_RW-1:0] r_sq_root;
    logic        [SQ_CW-1:0] r_sq_cnt;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;

    // output register
    logic               r_m_valid;
    logic        [63:0] r_m_data;

    // combinational datapath
    logic               in_beat, out_free;
    logic signed [31:0] meas_speed;
    logic signed [32:0] err;
    logic signed [1:0]  sgn_cur, sgn_prev;
    logic signed [2:0]  sign_sum;
    logic signed [34:0] step_ext, step_term, dist_sum;
    logic signed [31:0] dist_new;
    logic        [SQ_RW+1:0] sq_shift, sq_trial;
    logic               sq_take;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] term;
    logic signed [31:0] drive_new;
    logic signed [32:0] tin_sum;
    logic signed [31:0] speed_new;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // speed error, exact at 33 bits
    assign meas_speed = s_axis_tdata[63:32];
    assign err        = {r_speed_state[31], r_speed_state} - {meas_speed[31], meas_speed};

    // trapezoidal disturbance step: dist_step times (s + previous s)
    always_comb begin
        sgn_cur  = sign_val(r_sign);
        sgn_prev = sign_val(r_prev_sign);
        sign_sum = {sgn_cur[1], sgn_cur} + {sgn_prev[1], sgn_prev};
        step_ext = {{3{r_dist_step[31]}}, r_dist_step};
        case (sign_sum)
            3'b010:  step_term = step_ext <<< 1;
            3'b001:  step_term = step_ext;
            3'b111:  step_term = -step_ext;
            3'b110:  step_term = -(step_ext <<< 1);
            default: step_term = '0;
        endcase
        dist_sum = {{3{r_dist_state[31]}}, r_dist_state} + step_term;
        dist_new = clamp_sym(sat32(64'(dist_sum)), r_dist_limit);
    end

    // one root bit per cycle: bring down two radicand bits, try 4r+1
    assign sq_shift = {r_sq_rem[SQ_RW-1:0], r_sq_x[SQ_PW-1 -: 2]};
    assign sq_trial = {r_sq_root, 2'b01};
    assign sq_take  = (sq_shift >= sq_trial);

    // shared multiplier operand select
    always_comb begin
        unique case (r_op)
            OP_IQ: begin
                mul_a = r_iq;
                mul_b = r_gain_iq;
            end
            OP_DIST: begin
                mul_a = r_dist;
                mul_b = r_gain_dist;
            end
            OP_ROOT: begin
                mul_a = 32'(r_sq_root);
                mul_b = r_k_root;
            end
            OP_TUSTIN: begin
                mul_a = r_speed_num;
                mul_b = r_tin;
            end
            OP_FEEDBACK: begin
                mul_a = r_speed_den;
                mul_b = r_speed_state;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    // round half up, then floor shift
    assign term = (r_prod + HALF_LSB) >>> FRAC_BITS;

    assign drive_new = sat32(r_acc);
    assign tin_sum   = {drive_new[31], drive_new} + {r_prev_drive[31], r_prev_drive};
    assign speed_new = clamp_sym(sat32(r_acc), r_speed_limit);

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_beat) n_state = ST_DIST;
            ST_DIST:   n_state = ST_SQRT;
            ST_SQRT:   if (r_sq_cnt == '0) n_state = ST_MUL;
            ST_MUL:    n_state = ST_ACC;
            ST_ACC: begin
                if (r_op == OP_ROOT)
                    n_state = ST_TIN;
                else if (r_op == OP_FEEDBACK)
                    n_state = ST_FINISH;
                else
                    n_state = ST_MUL;
            end
            ST_TIN:    n_state = ST_MUL;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_iq     <= '0;
            r_gain_dist   <= '0;
            r_dist_step   <= '0;
            r_speed_num   <= '0;
            r_speed_den   <= '0;
            r_k_root      <= '0;
            r_dist_limit  <= LIMIT_MAX;
            r_speed_limit <= LIMIT_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GAIN_IQ:     r_gain_iq     <= i_cfg_wdata;
                REG_GAIN_DIST:   r_gain_dist   <= i_cfg_wdata;
                REG_DIST_STEP:   r_dist_step   <= i_cfg_wdata;
                REG_SPEED_NUM:   r_speed_num   <= i_cfg_wdata;
                REG_SPEED_DEN:   r_speed_den   <= i_cfg_wdata;
                REG_K_ROOT:      r_k_root      <= i_cfg_wdata;
                REG_DIST_LIMIT:  r_dist_limit  <= i_cfg_wdata[30:0];
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // observer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_state <= '0;
            r_dist_state  <= '0;
            r_prev_drive  <= '0;
            r_prev_sign   <= SIGN_ZERO;
            r_m_valid     <= 1'b0;
        end else begin
            if (r_state == ST_FINISH && out_free) begin
                r_speed_state <= speed_new;
                r_dist_state  <= r_dist;
                r_prev_drive  <= r_drive;
                r_prev_sign   <= r_sign;
                r_m_valid     <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid     <= 1'b0;
            end
        end
    end

    // working datapath; payload only, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    r_iq  <= s_axis_tdata[31:0];
                    r_mag <= err[32] ? 33'(-err) : 33'(err);
                    if (err == '0)
                        r_sign <= SIGN_ZERO;
                    else if (err[32])
                        r_sign <= SIGN_NEG;
                    else
                        r_sign <= SIGN_POS;
                end
            end
            ST_DIST: begin
                r_dist    <= dist_new;
                r_sq_x    <= SQ_PW'(r_mag) << FRAC_BITS;
                r_sq_rem  <= '0;
                r_sq_root <= '0;
                r_sq_cnt  <= SQ_CW'(SQ_RW - 1);
                r_op      <= OP_IQ;
            end
            ST_SQRT: begin
                r_sq_x   <= r_sq_x << 2;
                r_sq_cnt <= r_sq_cnt - 1'b1;
                if (sq_take) begin
                    r_sq_rem  <= sq_shift - sq_trial;
                    r_sq_root <= {r_sq_root[SQ_RW-2:0], 1'b1};
                end else begin
                    r_sq_rem  <= sq_shift;
                    r_sq_root <= {r_sq_root[SQ_RW-2:0], 1'b0};
                end
            end
            ST_MUL: begin
                r_prod <= prod;
            end
            ST_ACC: begin
                case (r_op)
                    OP_IQ, OP_TUSTIN: r_acc <= term;
                    OP_DIST:          r_acc <= r_acc - term;
                    OP_ROOT: begin
                        if (r_sign == SIGN_POS)
                            r_acc <= r_acc - term;
                        else if (r_sign == SIGN_NEG)
                            r_acc <= r_acc + term;
                    end
                    OP_FEEDBACK:      r_acc <= r_acc + term;
                    default: ;
                endcase
                case (r_op)
                    OP_IQ:    r_op <= OP_DIST;
                    OP_DIST:  r_op <= OP_ROOT;
                    OP_TUSTIN: r_op <= OP_FEEDBACK;
                    default: ;
                endcase
            end
            ST_TIN: begin
                // drive saturates, then the Tustin input sum saturates again
                r_drive <= drive_new;
                r_tin   <= sat32(64'(tin_sum));
                r_op    <= OP_TUSTIN;
            end
            ST_FINISH: begin
                if (out_free)
                    r_m_data <= {r_dist, speed_new};
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // an accepted sample drops ready in the cycle after it
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample accepted while the previous one is in flight");

    // a result appears only out of the completion step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_FINISH))
        else $error("result raised outside completion");

    // held disturbance estimate respects its clamp
    a_dist_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed({m_axis_tdata[63], m_axis_tdata[63:32]}) <=
             $signed({2'b00, r_dist_limit})) &&
            ($signed({m_axis_tdata[63], m_axis_tdata[63:32]}) >=
             -$signed({2'b00, r_dist_limit})))
        else $error("disturbance estimate beyond its limit");

    // square-root loop always leaves into the multiply phase on the first product
    a_sqrt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT && r_sq_cnt == '0) |=> (r_state == ST_MUL && r_op == OP_IQ))
        else $error("square-root loop exit out of order");
`endif

endmodule

`default_nettype wire
